// ----- rtl/tvpt_pkg.sv -----
// Shared constants and fixed-point helpers for the two-view triangulation block.
// Depends on nothing; used by tvpt_div and two_view_point_triangulation.
package tvpt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_COEFS     = 30;
  localparam int DATA_W        = 32;
  localparam int IDX_W         = 5;

  // operation codes of an input word
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_POINT = 1'b1;

  // coefficient store layout
  localparam int POSE1_BASE = 6;
  localparam int POSE2_BASE = 18;

  // exact product, rounded to nearest by floor((a*b + half) >> f)
  function automatic logic signed [63:0] rprod(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input int f);
    logic signed [63:0] p;
    logic signed [63:0] half;
    p    = 64'(a) * 64'(b);
    half = 64'sd1 <<< (f - 1);
    return (p + half) >>> f;
  endfunction

  // clamp a wide signed sum into 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/tvpt_div.sv -----
// One lane of the pipelined signed divider: trunc(num * 2^FRAC_BITS / den), saturated.
// One restoring step per register stage. Depends on tvpt_pkg.
module tvpt_div #(
  parameter int FRAC_BITS = tvpt_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                vld_in,
  input  logic signed [tvpt_pkg::DATA_W-1:0]  num,
  input  logic signed [tvpt_pkg::DATA_W-1:0]  den,
  output logic                                vld_out,
  output logic                                zero_out,
  output logic signed [tvpt_pkg::DATA_W-1:0]  quo
);

  localparam int NW    = 32 + FRAC_BITS;
  localparam int STEPS = 32;

  // per-stage state, index 0 is the setup stage
  logic        v_r    [STEPS+1];
  logic        neg_r  [STEPS+1];
  logic        ovf_r  [STEPS+1];
  logic        zero_r [STEPS+1];
  logic [31:0] d_r    [STEPS+1];
  logic [63:0] w_r    [STEPS+1];

  logic [31:0]          num_mag;
  logic [31:0]          den_mag;
  logic [NW-1:0]        n_full;
  logic [FRAC_BITS-1:0] n_hi;
  logic [31:0]          n_hi_ext;

  // take magnitudes and check that the quotient fits in 32 bits
  always_comb begin
    num_mag  = num[31] ? (~num + 32'd1) : num;
    den_mag  = den[31] ? (~den + 32'd1) : den;
    n_full   = {num_mag, {FRAC_BITS{1'b0}}};
    n_hi     = n_full[NW-1:32];
    n_hi_ext = {{(32-FRAC_BITS){1'b0}}, n_hi};
  end

  // setup stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    neg_r[0]  <= num[31] ^ den[31];
    ovf_r[0]  <= (n_hi_ext >= den_mag);
    zero_r[0] <= (den == '0);
    d_r[0]    <= den_mag;
    w_r[0]    <= {n_hi_ext, n_full[31:0]};
  end

  // restoring steps, one quotient bit per stage
  for (genvar i = 1; i <= STEPS; i++) begin : g_step
    logic [32:0] t;
    logic        ge;
    logic [32:0] r;

    always_comb begin
      t  = w_r[i-1][63:31];
      ge = (t >= {1'b0, d_r[i-1]});
      r  = ge ? (t - {1'b0, d_r[i-1]}) : t;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      neg_r[i]  <= neg_r[i-1];
      ovf_r[i]  <= ovf_r[i-1];
      zero_r[i] <= zero_r[i-1];
      d_r[i]    <= d_r[i-1];
      w_r[i]    <= {r[31:0], w_r[i-1][30:0], ge};
    end
  end

  logic [31:0]        q_mag;
  logic signed [31:0] q_nxt;

  // apply sign and saturate
  always_comb begin
    q_mag = w_r[STEPS][31:0];
    if (zero_r[STEPS]) begin
      q_nxt = '0;
    end else if (ovf_r[STEPS] || q_mag[31]) begin
      q_nxt = neg_r[STEPS] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      q_nxt = neg_r[STEPS] ? -$signed(q_mag) : $signed(q_mag);
    end
  end

  logic vld_r;
  logic zero_out_r;
  logic signed [31:0] quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= v_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    quo_r      <= q_nxt;
    zero_out_r <= zero_r[STEPS];
  end

  assign vld_out  = vld_r;
  assign zero_out = zero_out_r;
  assign quo      = quo_r;

endmodule

// ----- rtl/two_view_point_triangulation.sv -----
// Top level of the two-view point triangulation pipeline.
// Depends on tvpt_pkg and tvpt_div.
//
//  channel  ports                                       handshake
//  input    in_op, in_coef_index, in_coef_value,        start, busy
//           in_u1, in_v1, in_u2, in_v2
//  result   out_pos_x, out_pos_y, out_pos_z,            out_valid (one-cycle strobe)
//           out_degenerate
//
// A word is taken on each cycle that start is high; busy stays low, so one point per cycle.
// A point result passes through eight arithmetic stages (camera
// products, linear system, normal equations, determinants) and a 34-stage divider.
// A load writes the coefficient store at once and gives no result; points already in
// flight have captured their camera products and are not affected.
// Reset clears the valid bits; the coefficient store is undefined until written.
module two_view_point_triangulation #(
  parameter int FRAC_BITS = tvpt_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_op,
  input  logic [tvpt_pkg::IDX_W-1:0]           in_coef_index,
  input  logic signed [tvpt_pkg::DATA_W-1:0]   in_coef_value,
  input  logic signed [tvpt_pkg::DATA_W-1:0]   in_u1,
  input  logic signed [tvpt_pkg::DATA_W-1:0]   in_v1,
  input  logic signed [tvpt_pkg::DATA_W-1:0]   in_u2,
  input  logic signed [tvpt_pkg::DATA_W-1:0]   in_v2,
  output logic                                 out_valid,
  output logic signed [tvpt_pkg::DATA_W-1:0]   out_pos_x,
  output logic signed [tvpt_pkg::DATA_W-1:0]   out_pos_y,
  output logic signed [tvpt_pkg::DATA_W-1:0]   out_pos_z,
  output logic                                 out_degenerate
);

  localparam int DIV_LAT = 34;

  logic acc;
  logic pt_acc;

  // the pipeline never stalls
  assign busy   = 1'b0;
  assign acc    = start && !busy;
  assign pt_acc = acc && (in_op == tvpt_pkg::OP_POINT);

  // coefficient store
  logic signed [31:0] coef_r [tvpt_pkg::NUM_COEFS];

  always_ff @(posedge clk) begin
    if (acc && (in_op == tvpt_pkg::OP_LOAD) && (in_coef_index < 5'(tvpt_pkg::NUM_COEFS))) begin
      coef_r[in_coef_index] <= in_coef_value;
    end
  end

  // stage valid bits
  logic v_r [1:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= 8; s++) v_r[s] <= 1'b0;
    end else begin
      v_r[1] <= pt_acc;
      for (int s = 2; s <= 8; s++) v_r[s] <= v_r[s-1];
    end
  end

  // stage 1: camera and pixel products
  logic signed [31:0] px [4];
  logic signed [63:0] kp_r [2][2][4][3];
  logic signed [63:0] pp_r [2][2][4];

  assign px[0] = in_u1;
  assign px[1] = in_v1;
  assign px[2] = in_u2;
  assign px[3] = in_v2;

  always_ff @(posedge clk) begin
    for (int w = 0; w < 2; w++) begin
      for (int r = 0; r < 2; r++) begin
        for (int c = 0; c < 4; c++) begin
          for (int k = 0; k < 3; k++) begin
            kp_r[w][r][c][k] <= tvpt_pkg::rprod(coef_r[3*r+k],
              coef_r[tvpt_pkg::POSE1_BASE + 12*w + 4*k + c], FRAC_BITS);
          end
          pp_r[w][r][c] <= tvpt_pkg::rprod(px[2*w+r],
            coef_r[tvpt_pkg::POSE1_BASE + 12*w + 8 + c], FRAC_BITS);
        end
      end
    end
  end

  // stage 2: rows of the linear system
  logic signed [31:0] a_r [4][3];
  logic signed [31:0] b_r [4];

  always_ff @(posedge clk) begin
    for (int w = 0; w < 2; w++) begin
      for (int r = 0; r < 2; r++) begin
        for (int c = 0; c < 4; c++) begin
          if (c < 3) begin
            a_r[2*w+r][c] <= tvpt_pkg::sat32(pp_r[w][r][c] - 64'(tvpt_pkg::sat32(
              kp_r[w][r][c][0] + kp_r[w][r][c][1] + kp_r[w][r][c][2])));
          end else begin
            b_r[2*w+r] <= tvpt_pkg::sat32(64'(tvpt_pkg::sat32(
              kp_r[w][r][c][0] + kp_r[w][r][c][1] + kp_r[w][r][c][2])) - pp_r[w][r][c]);
          end
        end
      end
    end
  end

  // stage 3: products of the normal equations
  logic signed [63:0] np_r [3][3][4];
  logic signed [63:0] rp_r [3][4];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 3; j++) begin
          np_r[i][j][k] <= tvpt_pkg::rprod(a_r[k][i], a_r[k][j], FRAC_BITS);
        end
        rp_r[i][k] <= tvpt_pkg::rprod(a_r[k][i], b_r[k], FRAC_BITS);
      end
    end
  end

  // stage 4: normal matrix and right-hand side
  logic signed [31:0] n_r [3][3];
  logic signed [31:0] rv_r [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        n_r[i][j] <= tvpt_pkg::sat32(np_r[i][j][0] + np_r[i][j][1] +
                                     np_r[i][j][2] + np_r[i][j][3]);
      end
      rv_r[i] <= tvpt_pkg::sat32(rp_r[i][0] + rp_r[i][1] + rp_r[i][2] + rp_r[i][3]);
    end
  end

  // stage 5: cofactor products for det(N) and the three column swaps
  logic signed [31:0] m [4][3][3];
  logic signed [63:0] cp_r [4][3][2];
  logic signed [31:0] row0_5_r [4][3];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          m[l][i][j] = (l > 0 && j == l - 1) ? rv_r[i] : n_r[i][j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      cp_r[l][0][0] <= tvpt_pkg::rprod(m[l][1][1], m[l][2][2], FRAC_BITS);
      cp_r[l][0][1] <= tvpt_pkg::rprod(m[l][1][2], m[l][2][1], FRAC_BITS);
      cp_r[l][1][0] <= tvpt_pkg::rprod(m[l][1][0], m[l][2][2], FRAC_BITS);
      cp_r[l][1][1] <= tvpt_pkg::rprod(m[l][1][2], m[l][2][0], FRAC_BITS);
      cp_r[l][2][0] <= tvpt_pkg::rprod(m[l][1][0], m[l][2][1], FRAC_BITS);
      cp_r[l][2][1] <= tvpt_pkg::rprod(m[l][1][1], m[l][2][0], FRAC_BITS);
      for (int j = 0; j < 3; j++) row0_5_r[l][j] <= m[l][0][j];
    end
  end

  // stage 6: cofactors
  logic signed [31:0] cof_r [4][3];
  logic signed [31:0] row0_6_r [4][3];

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      for (int j = 0; j < 3; j++) begin
        cof_r[l][j]    <= tvpt_pkg::sat32(cp_r[l][j][0] - cp_r[l][j][1]);
        row0_6_r[l][j] <= row0_5_r[l][j];
      end
    end
  end

  // stage 7: expansion along the top row
  logic signed [63:0] dp_r [4][3];

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      for (int j = 0; j < 3; j++) begin
        dp_r[l][j] <= tvpt_pkg::rprod(row0_6_r[l][j], cof_r[l][j], FRAC_BITS);
      end
    end
  end

  // stage 8: determinants
  logic signed [31:0] det_r [4];

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      det_r[l] <= tvpt_pkg::sat32(dp_r[l][0] - dp_r[l][1] + dp_r[l][2]);
    end
  end

  // divider lanes, one per coordinate
  logic               dv_v    [3];
  logic               dv_zero [3];
  logic signed [31:0] dv_q    [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    tvpt_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .vld_in   (v_r[8]),
      .num      (det_r[k+1]),
      .den      (det_r[0]),
      .vld_out  (dv_v[k]),
      .zero_out (dv_zero[k]),
      .quo      (dv_q[k])
    );
  end

  assign out_valid      = dv_v[0];
  assign out_pos_x      = dv_q[0];
  assign out_pos_y      = dv_q[1];
  assign out_pos_z      = dv_q[2];
  assign out_degenerate = dv_zero[0];

  // a singular system reports the origin
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_pos_x == '0 && out_pos_y == '0 && out_pos_z == '0)
    else $error("degenerate result with nonzero position");

  // every result comes from a word that left the determinant stage
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(v_r[8], DIV_LAT))
    else $error("result without a matching word");

  // divider lanes stay in lockstep
  a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    dv_v[0] == dv_v[1] && dv_v[0] == dv_v[2] &&
    (!dv_v[0] || (dv_zero[0] == dv_zero[1] && dv_zero[0] == dv_zero[2])))
    else $error("divider lanes out of step");

endmodule
